FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the decoder modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock outside reset
`define BFCD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising clock outside reset
`define BFCD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/bfcd_pkg.sv
// ---------------------------------------------------------------------------
// bfcd_pkg
// shared types and constants of the banked flash command decoder
// ---------------------------------------------------------------------------
package bfcd_pkg;

  localparam int unsigned OffsetW     = 19;
  localparam int unsigned DataW       = 8;
  localparam int unsigned AddrW       = 20;
  localparam int unsigned SectorBytes = 4096;
  localparam int unsigned SectorBits  = $clog2(SectorBytes);

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned OpW      = 3;

  // short queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [OffsetW-1:0] AddrUnlockA = OffsetW'(20'h05555);
  localparam logic [OffsetW-1:0] AddrUnlockB = OffsetW'(20'h02AAA);

  localparam logic [DataW-1:0] CmdUnlock1 = 8'hAA;
  localparam logic [DataW-1:0] CmdUnlock2 = 8'h55;
  localparam logic [DataW-1:0] CmdProgram = 8'hA0;
  localparam logic [DataW-1:0] CmdErase   = 8'h80;
  localparam logic [DataW-1:0] CmdSector  = 8'h30;
  localparam logic [DataW-1:0] CmdReset   = 8'hF0;

  localparam logic [DataW-1:0] BankLow  = 8'h84;
  localparam logic [DataW-1:0] BankMid  = 8'h86;
  localparam logic [DataW-1:0] BankBoot = 8'h87;

  // upper two address bits of each bank base (0x00000, 0x80000, 0xC0000)
  localparam logic [1:0] BaseHiLow  = 2'b00;
  localparam logic [1:0] BaseHiMid  = 2'b10;
  localparam logic [1:0] BaseHiBoot = 2'b11;

  typedef enum logic [OpW-1:0] {
    OP_NONE  = 3'd0,
    OP_PROG  = 3'd1,
    OP_ERASE = 3'd2,
    OP_RESET = 3'd3,
    OP_ABORT = 3'd4
  } op_e;

  // classified request handed from front to back
  typedef struct packed {
    op_e                op;
    logic               window;
    logic [1:0]         base_hi;
    logic [OffsetW-1:0] offset;
    logic [DataW-1:0]   pdata;
    logic               bank_valid;
  } cmd_t;

endpackage

FILE: hw/rtl/bfcd_front.sv
// ---------------------------------------------------------------------------
// bfcd_front
// accepts bus writes, tracks bank and unlock sequence, classifies requests
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bfcd_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  logic                     func_i,
  input  logic [bfcd_pkg::OffsetW-1:0] offset_i,
  input  logic [bfcd_pkg::DataW-1:0]   data_i,
  input  logic                     q_full_i,
  output logic                     push_o,
  output bfcd_pkg::cmd_t           cmd_o
);
  import bfcd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_U1,
    ST_U2,
    ST_PROG,
    ST_E1,
    ST_E2,
    ST_E3
  } seq_e;

  seq_e             state_q, state_d;
  logic [DataW-1:0] bank_q, bank_d;
  logic             accept;
  logic             at_a, at_b;
  op_e              op;

  assign req_ready_o = !q_full_i;
  assign accept      = req_valid_i && req_ready_o;
  assign push_o      = accept;

  assign at_a = (offset_i == AddrUnlockA);
  assign at_b = (offset_i == AddrUnlockB);

  always_comb begin
    state_d = state_q;
    bank_d  = bank_q;
    op      = OP_NONE;
    if (func_i) begin
      bank_d = data_i;
    end else if (state_q == ST_PROG) begin
      op      = OP_PROG;
      state_d = ST_IDLE;
    end else if (data_i == CmdReset) begin
      op      = OP_RESET;
      state_d = ST_IDLE;
    end else begin
      state_d = ST_IDLE;
      unique case (state_q)
        ST_IDLE: begin
          if (at_a && data_i == CmdUnlock1) state_d = ST_U1;
        end
        ST_U1: begin
          if (at_b && data_i == CmdUnlock2) state_d = ST_U2;
          else op = OP_ABORT;
        end
        ST_U2: begin
          if (at_a && data_i == CmdProgram) state_d = ST_PROG;
          else if (at_a && data_i == CmdErase) state_d = ST_E1;
          else op = OP_ABORT;
        end
        ST_E1: begin
          if (at_a && data_i == CmdUnlock1) state_d = ST_E2;
          else op = OP_ABORT;
        end
        ST_E2: begin
          if (at_b && data_i == CmdUnlock2) state_d = ST_E3;
          else op = OP_ABORT;
        end
        ST_E3: begin
          if (data_i == CmdSector) op = OP_ERASE;
          else op = OP_ABORT;
        end
        default: op = OP_ABORT;
      endcase
    end
  end

  always_comb begin
    cmd_o.op         = op;
    cmd_o.window     = !func_i;
    cmd_o.offset     = offset_i;
    cmd_o.pdata      = (op == OP_PROG) ? data_i : '0;
    cmd_o.bank_valid = (bank_d == BankLow) || (bank_d == BankMid) || (bank_d == BankBoot);
    case (bank_q)
      BankMid:  cmd_o.base_hi = BaseHiMid;
      BankBoot: cmd_o.base_hi = BaseHiBoot;
      default:  cmd_o.base_hi = BaseHiLow;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bank_q  <= BankBoot;
    end else if (accept) begin
      state_q <= state_d;
      bank_q  <= bank_d;
    end
  end

  // a window write in the program-data state always ends the sequence
  `BFCD_ASSERT_NEXT(a_prog_ends, accept && !func_i && state_q == ST_PROG,
                    state_q == ST_IDLE, "program state did not return to idle")

  // bank writes never move the unlock sequence
  `BFCD_ASSERT_NEXT(a_bank_keeps_seq, accept && func_i,
                    state_q == $past(state_q), "bank write changed sequence state")

endmodule

FILE: hw/rtl/bfcd_queue.sv
// ---------------------------------------------------------------------------
// bfcd_queue
// short register queue between front and back
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bfcd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bfcd_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output bfcd_pkg::cmd_t pop_cmd_o
);
  import bfcd_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o    = (cnt_q == QCntW'(QDepth));
  assign valid_o   = (cnt_q != '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  `BFCD_ASSERT_NOW(a_no_overflow, push_i, !full_o, "push into full queue")
  `BFCD_ASSERT_NOW(a_no_underflow, pop_i, valid_o, "pop from empty queue")

endmodule

FILE: hw/rtl/bfcd_back.sv
// ---------------------------------------------------------------------------
// bfcd_back
// forms physical addresses and holds the result register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bfcd_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  bfcd_pkg::cmd_t          cmd_i,
  output logic                    pop_o,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output bfcd_pkg::op_e           res_op_o,
  output logic [bfcd_pkg::AddrW-1:0] res_addr_o,
  output logic [bfcd_pkg::DataW-1:0] res_pdata_o,
  output logic                    res_bank_valid_o
);
  import bfcd_pkg::*;

  logic             valid_q;
  op_e              op_q;
  logic [AddrW-1:0] addr_q, addr_d, sum;
  logic [DataW-1:0] pdata_q;
  logic             bank_valid_q;
  logic             load;

  assign load  = q_valid_i && (!valid_q || res_ready_i);
  assign pop_o = load;

  // base + offset wraps at the address width
  assign sum = {cmd_i.base_hi, {(AddrW-2){1'b0}}} + {1'b0, cmd_i.offset};

  always_comb begin
    if (!cmd_i.window) addr_d = '0;
    else if (cmd_i.op == OP_ERASE) addr_d = {sum[AddrW-1:SectorBits], {SectorBits{1'b0}}};
    else addr_d = sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (res_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q         <= cmd_i.op;
      addr_q       <= addr_d;
      pdata_q      <= cmd_i.pdata;
      bank_valid_q <= cmd_i.bank_valid;
    end
  end

  assign res_valid_o      = valid_q;
  assign res_op_o         = op_q;
  assign res_addr_o       = addr_q;
  assign res_pdata_o      = pdata_q;
  assign res_bank_valid_o = bank_valid_q;

  // erase results always point at a sector boundary
  `BFCD_ASSERT_NOW(a_erase_aligned, valid_q && op_q == OP_ERASE,
                   addr_q[SectorBits-1:0] == '0, "erase address not sector aligned")

endmodule

FILE: hw/rtl/banked_flash_command_decoder_top.sv
// ---------------------------------------------------------------------------
// banked_flash_command_decoder_top
// decodes bus writes into program, erase and reset requests on a banked flash
// ---------------------------------------------------------------------------
// usage
//   slave channel: one bus write per request; tuser selects a bank register
//   write (1) or a flash window write (0), tdata carries offset and byte
//   master channel: one result per accepted request; tuser holds the
//   operation code, tdata the physical address, program byte and bank flag
//   path: an accepted request is written into the queue, then loaded into the result register
//   throughput: one request per clock while the receiver keeps tready high;
//   the sequence state machine in the front decides each write combinationally
//   and the address adder in the back forms the physical address combinationally
//   reset: sequence returns to idle, current bank becomes the boot bank
//   (0x87), the queue and result register empty
//   stall: while the receiver holds tready low the result register holds,
//   the two-entry queue keeps taking requests, and tready on the slave side
//   drops only once the queue is full
// ---------------------------------------------------------------------------
module banked_flash_command_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [18:0] offset, [26:19] data, [31:27] zero
  input  logic [0:0]  s_axis_tuser,   // [0] func
  // result side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [19:0] phys_address, [27:20] program_data,
                                      // [28] bank_valid, [31:29] zero
  output logic [2:0]  m_axis_tuser    // [2:0] operation
);
  import bfcd_pkg::*;

  // front to queue
  logic push, q_full;
  cmd_t front_cmd;

  // queue to back
  logic q_valid, pop;
  cmd_t q_cmd;

  // result register contents
  op_e              res_op;
  logic [AddrW-1:0] res_addr;
  logic [DataW-1:0] res_pdata;
  logic             res_bank_valid;

  // front: bank register and unlock sequence
  bfcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .func_i      (s_axis_tuser[0]),
    .offset_i    (s_axis_tdata[OffsetW-1:0]),
    .data_i      (s_axis_tdata[OffsetW+DataW-1:OffsetW]),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  // queue lets the front keep accepting while the receiver stalls
  bfcd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (front_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (q_cmd)
  );

  // back: address forming and result register
  bfcd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .cmd_i            (q_cmd),
    .pop_o            (pop),
    .res_valid_o      (m_axis_tvalid),
    .res_ready_i      (m_axis_tready),
    .res_op_o         (res_op),
    .res_addr_o       (res_addr),
    .res_pdata_o      (res_pdata),
    .res_bank_valid_o (res_bank_valid)
  );

  // pack result fields from the lowest bit up, zero fill to 32 bits
  assign m_axis_tdata = {(OutDataW-AddrW-DataW-1)'(0), res_bank_valid, res_pdata, res_addr};
  assign m_axis_tuser = res_op;

endmodule
